>>> design/tmq_pkg.sv
// shared types and codes for the timed message queue
`default_nettype none

package tmq_pkg;

  typedef enum logic [2:0] {
    STAT_ENQUEUED = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_DELIVER  = 3'd2,
    STAT_NOT_DUE  = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_SHIFT  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

>>> design/tmq_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module tmq_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/timed_message_queue_core.sv
// timed message queue: entry store, earliest-due scan and removal sequencer
//
// channel   direction  handshake                payload
// command   in         start high, busy low     command_i, message_tag_i, due_time_i,
//                                               current_time_i
// result    out        done_o, one cycle        status_o, delivered_tag_o, wait_time_o,
//                                               pending_count_o
//
// enqueue, full and empty words: result in the cycle after start, busy stays low
// poll: busy while the scan runs through the single ram read port and the shared
// subtractor, and on delivery while the entries behind the removed one move up to close
// the gap; the result shows in the same cycle that busy drops
// reset clears the fill count and the sequencer; the ram needs no clearing pass
// results cannot be stalled; busy holds off new words while a poll runs
`default_nettype none

module timed_message_queue_core #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 40,
  parameter int TAG_BITS  = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           command_i,
  input  wire logic [TAG_BITS-1:0]            message_tag_i,
  input  wire logic [TIME_BITS-1:0]           due_time_i,
  input  wire logic [TIME_BITS-1:0]           current_time_i,
  output logic                                done_o,
  output logic [2:0]                          status_o,
  output logic [TAG_BITS-1:0]                 delivered_tag_o,
  output logic [TIME_BITS-1:0]                wait_time_o,
  output logic [$clog2(DEPTH+1)-1:0]          pending_count_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = TIME_BITS + TAG_BITS;

  tmq_pkg::state_e  state_q, state_d;
  tmq_pkg::status_e status_q, status_d;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     ptr_q, ptr_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                 best_vld_q, best_vld_d;
  logic [TIME_BITS-1:0] best_due_q, best_due_d;
  logic [TAG_BITS-1:0]  best_tag_q, best_tag_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic                 wr_vld_q, wr_vld_d;
  logic [IDX_W-1:0]     wr_addr_q, wr_addr_d;
  logic                 done_q, done_d;
  logic [TAG_BITS-1:0]  tag_out_q, tag_out_d;
  logic [TIME_BITS-1:0] wait_q, wait_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;
  logic [TIME_BITS-1:0] rd_due;
  logic [TAG_BITS-1:0]  rd_tag;

  logic [TIME_BITS-1:0] sub_a, sub_b;
  logic [TIME_BITS:0]   sub_res;
  logic                 sub_borrow;
  logic [TIME_BITS-1:0] sub_diff;

  logic                 issue;
  logic [CNT_W-1:0]     ptr_m1;

  tmq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_due = ram_rdata[TIME_BITS-1:0];
  assign rd_tag = ram_rdata[TIME_BITS +: TAG_BITS];

  // shared subtractor: scan compare, then due check and wait time
  always_comb begin
    if (state_q == tmq_pkg::S_SCAN) begin
      sub_a = rd_due;
      sub_b = best_due_q;
    end else begin
      sub_a = best_due_q;
      sub_b = now_q;
    end
  end

  assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_res[TIME_BITS];
  assign sub_diff   = sub_res[TIME_BITS-1:0];

  assign busy   = (state_q != tmq_pkg::S_IDLE);
  assign issue  = (ptr_q < count_q);
  assign ptr_m1 = ptr_q - CNT_W'(1);

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    best_vld_d = best_vld_q;
    best_due_d = best_due_q;
    best_tag_d = best_tag_q;
    best_idx_d = best_idx_q;
    now_d      = now_q;
    wr_vld_d   = wr_vld_q;
    wr_addr_d  = wr_addr_q;
    done_d     = 1'b0;
    tag_out_d  = tag_out_q;
    wait_d     = wait_q;
    ram_we     = 1'b0;
    ram_waddr  = count_q[IDX_W-1:0];
    ram_wdata  = {message_tag_i, due_time_i};

    case (state_q)
      tmq_pkg::S_IDLE: begin
        if (start) begin
          if (!command_i) begin
            done_d    = 1'b1;
            tag_out_d = '0;
            wait_d    = '0;
            if (count_q == CNT_W'(DEPTH)) begin
              status_d = tmq_pkg::STAT_FULL;
            end else begin
              ram_we   = 1'b1;
              count_d  = count_q + CNT_W'(1);
              status_d = tmq_pkg::STAT_ENQUEUED;
            end
          end else if (count_q == '0) begin
            done_d    = 1'b1;
            tag_out_d = '0;
            wait_d    = '0;
            status_d  = tmq_pkg::STAT_EMPTY;
          end else begin
            now_d      = current_time_i;
            ptr_d      = '0;
            cmp_vld_d  = 1'b0;
            best_vld_d = 1'b0;
            state_d    = tmq_pkg::S_SCAN;
          end
        end
      end
      tmq_pkg::S_SCAN: begin
        cmp_vld_d = issue;
        cmp_idx_d = ptr_q[IDX_W-1:0];
        if (issue) begin
          ptr_d = ptr_q + CNT_W'(1);
        end
        // strict less keeps the oldest among equal due times
        if (cmp_vld_q && (!best_vld_q || sub_borrow)) begin
          best_vld_d = 1'b1;
          best_due_d = rd_due;
          best_tag_d = rd_tag;
          best_idx_d = cmp_idx_q;
        end
        if (!issue && !cmp_vld_q) begin
          state_d = tmq_pkg::S_DECIDE;
        end
      end
      tmq_pkg::S_DECIDE: begin
        if (sub_borrow || (sub_diff == '0)) begin
          tag_out_d = best_tag_q;
          wait_d    = '0;
          ptr_d     = CNT_W'(best_idx_q) + CNT_W'(1);
          wr_vld_d  = 1'b0;
          state_d   = tmq_pkg::S_SHIFT;
        end else begin
          done_d    = 1'b1;
          status_d  = tmq_pkg::STAT_NOT_DUE;
          tag_out_d = '0;
          wait_d    = sub_diff;
          state_d   = tmq_pkg::S_IDLE;
        end
      end
      tmq_pkg::S_SHIFT: begin
        // read entry i+1, write it to i in the following cycle
        wr_vld_d  = issue;
        wr_addr_d = ptr_m1[IDX_W-1:0];
        if (issue) begin
          ptr_d = ptr_q + CNT_W'(1);
        end
        if (wr_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q;
          ram_wdata = ram_rdata;
        end
        if (!issue && !wr_vld_q) begin
          count_d  = count_q - CNT_W'(1);
          done_d   = 1'b1;
          status_d = tmq_pkg::STAT_DELIVER;
          state_d  = tmq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tmq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tmq_pkg::S_IDLE;
      count_q    <= '0;
      ptr_q      <= '0;
      cmp_vld_q  <= 1'b0;
      best_vld_q <= 1'b0;
      wr_vld_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ptr_q      <= ptr_d;
      cmp_vld_q  <= cmp_vld_d;
      best_vld_q <= best_vld_d;
      wr_vld_q   <= wr_vld_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    cmp_idx_q  <= cmp_idx_d;
    best_due_q <= best_due_d;
    best_tag_q <= best_tag_d;
    best_idx_q <= best_idx_d;
    now_q      <= now_d;
    wr_addr_q  <= wr_addr_d;
    tag_out_q  <= tag_out_d;
    wait_q     <= wait_d;
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign delivered_tag_o = tag_out_q;
  assign wait_time_o     = wait_q;
  assign pending_count_o = count_q;

endmodule

`default_nettype wire

>>> design/tmq_checker.sv
// port-level checks for the timed message queue, bound to the top level
`default_nettype none

module tmq_checker #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 40
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      done_o,
  input wire logic [2:0]                status_o,
  input wire logic [TIME_BITS-1:0]      wait_time_o,
  input wire logic [$clog2(DEPTH+1)-1:0] pending_count_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // every accepted word answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted word neither answered nor in progress");

  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result shown while busy");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == tmq_pkg::STAT_FULL)) |-> (pending_count_o == CNT_W'(DEPTH)))
    else $error("full reported with free entries");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == tmq_pkg::STAT_EMPTY)) |-> (pending_count_o == '0))
    else $error("empty reported with entries held");

  a_wait_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != tmq_pkg::STAT_NOT_DUE)) |-> (wait_time_o == '0))
    else $error("wait time set on a word that is not a wait");

endmodule

bind timed_message_queue_core tmq_checker #(
  .DEPTH     (DEPTH),
  .TIME_BITS (TIME_BITS)
) u_tmq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .wait_time_o     (wait_time_o),
  .pending_count_o (pending_count_o)
);

`default_nettype wire
